/* rtl/ued_pkg.sv */
// Shared types and character constants for the backslash-u escape decoder.
package ued_pkg;

    // Character codes that the decoder recognizes or emits
    localparam logic [15:0] CH_BACKSLASH = 16'h005C;
    localparam logic [15:0] CH_U         = 16'h0075;
    localparam logic [15:0] CH_SPACE     = 16'h0020;
    localparam logic [15:0] CH_DIGIT_0   = 16'h0030;
    localparam logic [15:0] CH_DIGIT_9   = 16'h0039;
    localparam logic [15:0] CH_UPPER_A   = 16'h0041;
    localparam logic [15:0] CH_UPPER_F   = 16'h0046;
    localparam logic [15:0] CH_LOWER_A   = 16'h0061;
    localparam logic [15:0] CH_LOWER_F   = 16'h0066;

    // Value of hex letter 'A' minus its low nibble
    localparam logic [3:0] HEX_LETTER_OFFSET = 4'd9;

    // Most results that one input character can produce
    localparam int MAX_RESULTS = 6;

    // One queued result
    typedef struct packed {
        logic [15:0] code;
        logic        valid;
        logic        last;
    } ued_item_t;

endpackage

/* rtl/unicode_escape_decoder.sv */
// Backslash-u escape decoder: one character per cycle in unless stalled, results through a queue.
//
// The decoder accepts one 16-bit character per cycle while in_stall is low. Each accepted
// character is decoded in the cycle it is taken and produces from zero to six results, all
// written into a result queue of DEPTH entries in that same edge; the queue drains one
// result per cycle while res_stall is low. Plain text therefore runs at one character per
// cycle when neither side stalls, and each result is registered in the queue before it is
// offered. The input stalls while the queue has fewer than six free entries, so a broken
// escape that releases several held characters at once stalls the input until the queue
// drains below that mark. DEPTH must be a power of two, 8 or more.
module unicode_escape_decoder
    import ued_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [15:0] char_code,
    input  logic        last_char,
    output logic        res_valid,
    input  logic        res_stall,
    output logic [15:0] out_code,
    output logic        out_valid,
    output logic        out_last
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int NSLOT = MAX_RESULTS;

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_BSL  = 3'd1,
        PH_U    = 3'd2,
        PH_D1   = 3'd3,
        PH_D2   = 3'd4,
        PH_D3   = 3'd5
    } phase_t;

    phase_t          phase_reg;
    phase_t          phase_next;
    logic [11:0]     partial_reg;
    logic [11:0]     partial_next;
    logic [6:0]      held_reg [3];
    logic [6:0]      digits_eff [3];
    logic            held_we;
    logic [1:0]      held_idx;

    ued_item_t       mem_reg [DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] tail_reg;
    logic [CNT_W-1:0] count_reg;

    logic            in_xfer;
    logic            out_xfer;
    logic            hex_ok;
    logic [3:0]      hex_nib;
    logic [15:0]     full_value;
    logic            cont;
    logic            complete;
    logic [2:0]      flush_k;
    logic            has_x;
    logic [15:0]     x_code;
    logic            x_valid;
    logic [2:0]      n_res;
    logic [15:0]     seq_code [NSLOT];
    logic            slot_we [NSLOT];
    ued_item_t       slot_item [NSLOT];

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = res_valid && !res_stall;

    // Stall unless the queue can take a full burst of results
    assign in_stall  = count_reg > CNT_W'(DEPTH - MAX_RESULTS);
    assign res_valid = count_reg != '0;
    assign out_code  = mem_reg[head_reg].code;
    assign out_valid = mem_reg[head_reg].valid;
    assign out_last  = mem_reg[head_reg].last;

    // Classify the character as a hex digit
    always_comb
    begin
        hex_ok  = 1'b0;
        hex_nib = char_code[3:0];
        if (char_code >= CH_DIGIT_0 && char_code <= CH_DIGIT_9)
        begin
            hex_ok = 1'b1;
        end
        else if ((char_code >= CH_UPPER_A && char_code <= CH_UPPER_F) ||
                 (char_code >= CH_LOWER_A && char_code <= CH_LOWER_F))
        begin
            hex_ok  = 1'b1;
            hex_nib = char_code[3:0] + HEX_LETTER_OFFSET;
        end
    end

    assign full_value = {partial_reg, hex_nib};

    // Decode one character: next phase, held prefix length and trailing result
    always_comb
    begin
        phase_next    = phase_reg;
        partial_next  = partial_reg;
        held_we       = 1'b0;
        held_idx      = 2'(phase_reg - 3'd2);
        cont          = 1'b0;
        complete      = 1'b0;
        flush_k       = 3'd0;
        has_x         = 1'b0;
        x_code        = char_code;
        x_valid       = 1'b1;
        digits_eff    = held_reg;

        unique case (phase_reg)
            PH_BSL:
            begin
                cont = (char_code == CH_U);
            end
            PH_U, PH_D1, PH_D2:
            begin
                cont = hex_ok;
            end
            PH_D3:
            begin
                complete = hex_ok;
            end
            default:
            begin
                cont     = 1'b0;
                complete = 1'b0;
            end
        endcase

        if (cont)
        begin
            // Escape goes on: take the 'u' or store the digit, flush it all if the string ends
            phase_next = phase_t'(phase_reg + 3'd1);
            if (phase_reg == PH_BSL)
            begin
                partial_next = '0;
            end
            else
            begin
                partial_next         = full_value[11:0];
                held_we              = 1'b1;
                digits_eff[held_idx] = char_code[6:0];
            end
            if (last_char)
            begin
                flush_k    = phase_reg + 3'd1;
                phase_next = PH_IDLE;
            end
        end
        else if (complete)
        begin
            // Fourth digit: emit the named character unless its code is below a space
            phase_next = PH_IDLE;
            has_x      = full_value >= CH_SPACE;
            x_code     = full_value;
        end
        else
        begin
            // Broken or no escape: release what is held, then treat the char afresh
            phase_next = PH_IDLE;
            if (phase_reg == PH_BSL || phase_reg == PH_U || phase_reg == PH_D1 ||
                phase_reg == PH_D2 || phase_reg == PH_D3)
            begin
                flush_k = phase_reg;
            end
            if (char_code == CH_BACKSLASH)
            begin
                if (last_char)
                begin
                    has_x = 1'b1;
                end
                else
                begin
                    phase_next = PH_BSL;
                end
            end
            else
            begin
                has_x = 1'b1;
            end
        end

        n_res = flush_k + {2'b00, has_x};

        // Bare end marker when the final character yields nothing
        if (last_char && n_res == 3'd0)
        begin
            has_x   = 1'b1;
            x_code  = '0;
            x_valid = 1'b0;
            n_res   = 3'd1;
        end
    end

    // Build the result slots: held prefix first, then the trailing result
    always_comb
    begin
        seq_code[0] = CH_BACKSLASH;
        seq_code[1] = CH_U;
        seq_code[2] = {9'd0, digits_eff[0]};
        seq_code[3] = {9'd0, digits_eff[1]};
        seq_code[4] = {9'd0, digits_eff[2]};
        seq_code[5] = '0;
        for (int i = 0; i < NSLOT; i++)
        begin
            slot_we[i] = in_xfer && (3'(i) < n_res);
            if (3'(i) < flush_k)
            begin
                slot_item[i].code  = seq_code[i];
                slot_item[i].valid = 1'b1;
            end
            else
            begin
                slot_item[i].code  = x_code;
                slot_item[i].valid = x_valid;
            end
            slot_item[i].last = last_char && (3'(i) == n_res - 3'd1);
        end
    end

    // Hold escape state and queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_IDLE;
            partial_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                phase_reg   <= phase_next;
                partial_reg <= partial_next;
                tail_reg    <= tail_reg + PTR_W'(n_res);
            end
            if (out_xfer)
            begin
                head_reg <= head_reg + PTR_W'(1);
            end
            count_reg <= count_reg + (in_xfer ? CNT_W'(n_res) : CNT_W'(0))
                                   - (out_xfer ? CNT_W'(1) : CNT_W'(0));
        end
    end

    // Store held digits; no reset, an entry is read only after it is written
    always_ff @(posedge clk)
    begin
        if (in_xfer && held_we)
        begin
            held_reg[held_idx] <= char_code[6:0];
        end
    end

    // Write up to six results into the queue at the tail
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NSLOT; i++)
        begin
            if (slot_we[i])
            begin
                mem_reg[tail_reg + PTR_W'(i)] <= slot_item[i];
            end
        end
    end

endmodule

/* rtl/ued_checker.sv */
// Port-level assertions for the escape decoder, bound to its top level.
module ued_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic [15:0] char_code,
    input logic        last_char,
    input logic        res_valid,
    input logic        res_stall,
    input logic [15:0] out_code,
    input logic        out_valid,
    input logic        out_last
);

    // Stalled result holds its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(out_code) &&
                                   $stable(out_valid) && $stable(out_last))
        else $error("stalled result changed");

    // A bare end marker carries code zero and closes the string
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !out_valid |-> out_last && out_code == 16'd0)
        else $error("bare end marker malformed");

    // Empty queue never stalls the input
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_valid |-> !in_stall)
        else $error("input stalled with empty queue");

    // The final character of a string always leaves a result queued
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && last_char |=> res_valid)
        else $error("end of string produced no result");

endmodule

bind unicode_escape_decoder ued_checker u_ued_checker (.*);

/* tb/unicode_escape_decoder_tb.sv */
// Self-checking testbench for the backslash-u escape decoder.
`timescale 1ns / 1ps

module unicode_escape_decoder_tb
    import ued_pkg::*;
();

    localparam int          LIMIT_CYCLES    = 400000;
    localparam int          DRAIN_CYCLES    = 16;
    localparam int          MAX_REPORTS     = 10;
    localparam int          HEX_LETTER_BASE = 10;
    localparam logic [15:0] CH_LOWER_X      = 16'h0078;

    // Escape progress: backslash held, 'u' held, then one to three digits held
    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_BSLASH = 3'd1,
        PH_U      = 3'd2,
        PH_D1     = 3'd3,
        PH_D2     = 3'd4,
        PH_D3     = 3'd5
    } esc_phase_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] char_code = '0;
    logic        last_char = 1'b0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [15:0] out_code;
    logic        out_valid;
    logic        out_last;

    // Predictor state
    esc_phase_t  esc_phase = PH_IDLE;
    logic [6:0]  held_digits [3];
    logic [15:0] partial_word = '0;
    ued_item_t   step_q[$];
    ued_item_t   decoded_q[$];

    int          items_sent = 0;
    int          mismatches = 0;
    int          cycles = 0;
    int          stall_left = 0;
    logic        quiet = 1'b0;
    ued_item_t   got_item;
    ued_item_t   want_item;

    unicode_escape_decoder i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .char_code (char_code),
        .last_char (last_char),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .out_code  (out_code),
        .out_valid (out_valid),
        .out_last  (out_last)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("unicode_escape_decoder_tb NOT OK");
            $finish;
        end
    end

    function automatic int hex_nibble(input logic [15:0] c);
        if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9)
            return int'(c - CH_DIGIT_0);
        if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            return int'(c - CH_UPPER_A) + HEX_LETTER_BASE;
        if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            return int'(c - CH_LOWER_A) + HEX_LETTER_BASE;
        return -1;
    endfunction

    function automatic ued_item_t make_item(input logic [15:0] code, input logic valid);
        ued_item_t it;
        it.code  = code;
        it.valid = valid;
        it.last  = 1'b0;
        return it;
    endfunction

    // Release a held backslash, 'u' and digits unchanged
    function automatic void flush_escape();
        if (esc_phase >= PH_BSLASH && esc_phase <= PH_D3)
        begin
            step_q.push_back(make_item(CH_BACKSLASH, 1'b1));
            if (esc_phase >= PH_U)
                step_q.push_back(make_item(CH_U, 1'b1));
            for (int k = 0; k < int'(esc_phase) - int'(PH_U); k++)
                step_q.push_back(make_item({9'd0, held_digits[k]}, 1'b1));
        end
        esc_phase = PH_IDLE;
    endfunction

    function automatic void take_plain(input logic [15:0] c);
        if (c == CH_BACKSLASH)
            esc_phase = PH_BSLASH;
        else
            step_q.push_back(make_item(c, 1'b1));
    endfunction

    // Work out the decoded characters caused by one accepted character
    function automatic void decode_char(input logic [15:0] c, input logic last);
        int          nib;
        logic [15:0] word;
        step_q.delete();
        nib = hex_nibble(c);
        if (esc_phase == PH_BSLASH)
        begin
            if (c == CH_U)
            begin
                esc_phase    = PH_U;
                partial_word = '0;
            end
            else
            begin
                flush_escape();
                take_plain(c);
            end
        end
        else if (esc_phase >= PH_U && esc_phase <= PH_D3)
        begin
            if (nib < 0)
            begin
                flush_escape();
                take_plain(c);
            end
            else
            begin
                word         = {partial_word[11:0], nib[3:0]};
                partial_word = word;
                if (esc_phase != PH_D3)
                begin
                    held_digits[int'(esc_phase) - int'(PH_U)] = c[6:0];
                    esc_phase = esc_phase_t'(esc_phase + 3'd1);
                end
                else
                begin
                    esc_phase = PH_IDLE;
                    // drop codes below a space
                    if (word >= CH_SPACE)
                        step_q.push_back(make_item(word, 1'b1));
                end
            end
        end
        else
        begin
            esc_phase = PH_IDLE;
            take_plain(c);
        end
        // close the string
        if (last)
        begin
            flush_escape();
            if (step_q.size() == 0)
                step_q.push_back(make_item('0, 1'b0));
            step_q[step_q.size() - 1].last = 1'b1;
        end
        foreach (step_q[i])
            decoded_q.push_back(step_q[i]);
    endfunction

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    function automatic logic [15:0] hex_char(input logic [3:0] n);
        if (n < 4'd10)
            return CH_DIGIT_0 + 16'(n);
        if ($urandom_range(0, 1) == 1)
            return CH_UPPER_A + 16'(n) - 16'(HEX_LETTER_BASE);
        return CH_LOWER_A + 16'(n) - 16'(HEX_LETTER_BASE);
    endfunction

    // Pick a character that breaks an escape holding the given number of characters
    function automatic logic [15:0] rand_breaker(input int held);
        logic [15:0] c;
        do
        begin
            case ($urandom_range(0, 3))
                0: c = CH_BACKSLASH;
                1: c = CH_U;
                2: c = CH_LOWER_F + 16'd1;
                default: c = 16'($urandom);
            endcase
        end
        while (hex_nibble(c) >= 0 || (held == 1 && c == CH_U));
        return c;
    endfunction

    // Present one character and hold it until the transfer
    task automatic send_char(input logic [15:0] c, input logic last);
        int gap;
        gap = next_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        char_code <= c;
        last_char <= last;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        items_sent++;
        decode_char(c, last);
    endtask

    // Send the first n characters of the escape naming value
    task automatic send_escape(input int n, input logic [15:0] value, input logic last_final);
        logic [15:0] c;
        for (int i = 0; i < n; i++)
        begin
            if (i == 0)
                c = CH_BACKSLASH;
            else if (i == 1)
                c = CH_U;
            else
                c = hex_char(4'((value >> (4 * (5 - i))) & 16'hF));
            send_char(c, last_final && (i == n - 1));
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (decoded_q.size() != 0);
    endtask

    task automatic test_directed_cases();
        // extremes of plain characters
        send_char(16'h0000, 1'b0);
        send_char(16'hFFFF, 1'b0);
        // complete escapes
        send_escape(6, 16'h0041, 1'b0);
        send_escape(6, 16'hFFA9, 1'b0);
        // broken right after the backslash
        send_escape(1, 16'h0000, 1'b0);
        send_char(CH_LOWER_X, 1'b0);
        // broken after two digits by a new backslash that the string end releases
        send_escape(4, 16'h1200, 1'b0);
        send_char(CH_BACKSLASH, 1'b1);
        // decoded control character dropped at the end leaves a bare end marker
        send_escape(6, 16'h001F, 1'b1);
    endtask

    task automatic test_drain_pause();
        send_char(CH_BACKSLASH, 1'b0);
        wait_drained();
        send_char(CH_U, 1'b0);
        send_char(hex_char(4'h4), 1'b0);
        wait_drained();
        send_char(hex_char(4'h1), 1'b0);
        send_char(hex_char(4'h2), 1'b0);
        send_char(hex_char(4'h3), 1'b1);
        wait_drained();
    endtask

    task automatic test_burst_no_idle();
        quiet = 1'b1;
        // back-to-back broken escapes push full bursts of results into the queue
        repeat (12)
        begin
            send_escape(5, 16'($urandom), 1'b0);
            send_char(rand_breaker(5), 1'b0);
        end
        repeat (4) send_escape(6, 16'($urandom), 1'b0);
        send_char(16'($urandom_range(16'h20, 16'h7E)), 1'b1);
        quiet = 1'b0;
    endtask

    task automatic test_random_text(input int n_items);
        int          start;
        int          r;
        int          held;
        logic [15:0] value;
        logic        ends;
        start = items_sent;
        while (items_sent - start < n_items)
        begin
            quiet = ($urandom_range(0, 7) == 0);
            r     = $urandom_range(0, 99);
            ends  = ($urandom_range(0, 3) == 0);
            value = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 47)) : 16'($urandom);
            if (r < 40)
                send_escape(6, value, ends);
            else if (r < 60)
            begin
                held = $urandom_range(1, 5);
                send_escape(held, value, 1'b0);
                send_char(rand_breaker(held), ends);
            end
            else if (r < 70)
                send_escape($urandom_range(1, 5), value, 1'b1);
            else if (r < 85)
                send_char(value, ends);
            else
                send_char(16'($urandom_range(16'h20, 16'h7E)), ends);
        end
        quiet = 1'b0;
    endtask

    // Stall the result side in random bursts
    always @(posedge clk)
    begin
        if (quiet)
        begin
            stall_left = 0;
            res_stall <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left = stall_left - 1;
            res_stall <= 1'b1;
        end
        else if ($urandom_range(0, 99) < 60)
            res_stall <= 1'b0;
        else
        begin
            stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                      : $urandom_range(0, 2);
            res_stall <= 1'b1;
        end
    end

    task automatic log_mismatch(input string what, input ued_item_t want, input ued_item_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t %s: expected code %h valid %b last %b, got code %h valid %b last %b",
                     $realtime, what, want.code, want.valid, want.last,
                     got.code, got.valid, got.last);
    endtask

    // Compare each result transfer with the oldest pending result
    always @(posedge clk)
    begin
        if (rst_n && res_valid === 1'b1 && res_stall == 1'b0)
        begin
            got_item.code  = out_code;
            got_item.valid = out_valid;
            got_item.last  = out_last;
            if (decoded_q.size() == 0)
                log_mismatch("unexpected result", '0, got_item);
            else
            begin
                want_item = decoded_q.pop_front();
                if (got_item.code !== want_item.code || got_item.valid !== want_item.valid
                    || got_item.last !== want_item.last)
                    log_mismatch("result mismatch", want_item, got_item);
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_drain_pause();
        test_burst_no_idle();
        test_random_text(230);

        // drain what is still in flight
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (decoded_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && decoded_q.size() == 0)
            $display("unicode_escape_decoder_tb OK");
        else
            $display("unicode_escape_decoder_tb NOT OK");
        $finish;
    end

endmodule
